// ----- rtl/stepper_half_step_sequencer_unit_assert.svh -----
// assertion macros for the stepper sequencer
`ifndef STEPPER_HALF_STEP_SEQUENCER_UNIT_ASSERT_SVH
`define STEPPER_HALF_STEP_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define SHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/shs_pkg.sv -----
`default_nettype none
package shs_pkg;

  localparam int ANGLE_W = 16;
  localparam int PHASE_W = 4;
  localparam int SCALED_W = 26;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 8;

  // beat count is kept as angle * beats_per_turn, one beat per step of 360
  localparam logic [SCALED_W-1:0] DEG_STEP = SCALED_W'(360);
  // 131071 beats * 360 + 359, the largest scaled value still below saturation
  localparam logic [SCALED_W-1:0] SCALED_CAP = SCALED_W'(47185919);

  localparam logic [PHASE_W-1:0] COILS_OFF = 4'hF;

  typedef struct packed {
    logic                start;
    logic [SCALED_W-1:0] scaled;
    logic                reverse;
  } shs_item_t;

  typedef struct packed {
    logic               busy;
    logic [PHASE_W-1:0] phase;
  } shs_result_t;

  function automatic logic [PHASE_W-1:0] cw_code(input logic [2:0] slot);
    logic [PHASE_W-1:0] code;
    case (slot)
      3'd0: code = 4'hE;
      3'd1: code = 4'hC;
      3'd2: code = 4'hD;
      3'd3: code = 4'h9;
      3'd4: code = 4'hB;
      3'd5: code = 4'h3;
      3'd6: code = 4'h7;
      3'd7: code = 4'h6;
      default: code = COILS_OFF;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/shs_in_stage.sv -----
`default_nettype none
module shs_in_stage #(
  parameter int BEATS_PER_TURN = 512
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        mode,
  input  wire logic [shs_pkg::ANGLE_W-1:0] angle,
  input  wire logic                        direction,
  input  wire logic                        advance,
  output      logic                        out_valid,
  output      shs_pkg::shs_item_t          out_item
);

  localparam int BPT_W = $clog2(BEATS_PER_TURN + 1);
  localparam int PROD_W = shs_pkg::ANGLE_W + BPT_W;
  localparam int CMP_W = (PROD_W > shs_pkg::SCALED_W) ? PROD_W : shs_pkg::SCALED_W;

  logic [PROD_W-1:0]           product;
  logic                        saturate;
  logic [shs_pkg::SCALED_W-1:0] scaled;

  assign product = PROD_W'(angle) * PROD_W'(BEATS_PER_TURN);
  assign saturate = CMP_W'(product) > CMP_W'(shs_pkg::SCALED_CAP);
  assign scaled = saturate ? shs_pkg::SCALED_CAP : shs_pkg::SCALED_W'(product);

  assign in_ready = !out_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item.start   <= mode;
      out_item.scaled  <= scaled;
      out_item.reverse <= direction;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/shs_core.sv -----
`default_nettype none
module shs_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire shs_pkg::shs_item_t   item,
  output      shs_pkg::shs_result_t result
);

  logic [shs_pkg::SCALED_W-1:0] scaled, scaled_next;
  logic [2:0]                   index, index_next;
  logic                         reverse, reverse_next;
  logic [shs_pkg::PHASE_W-1:0]  phase_out, phase_out_next;
  logic [shs_pkg::SCALED_W-1:0] scaled_dec;
  logic                         beats_left;

  assign beats_left = scaled >= shs_pkg::DEG_STEP;
  assign scaled_dec = scaled - shs_pkg::DEG_STEP;

  always_comb begin
    scaled_next    = scaled;
    index_next     = index;
    reverse_next   = reverse;
    phase_out_next = phase_out;
    if (item.start) begin
      scaled_next  = item.scaled;
      reverse_next = item.reverse;
      index_next   = 3'd0;
      if (item.scaled < shs_pkg::DEG_STEP) begin
        phase_out_next = shs_pkg::COILS_OFF;
      end
    end else if (beats_left) begin
      // reverse walk: slot 7 - index
      phase_out_next = shs_pkg::cw_code(reverse ? ~index : index);
      index_next     = index + 3'd1;
      scaled_next    = scaled_dec;
    end else begin
      phase_out_next = shs_pkg::COILS_OFF;
    end
    result.phase = phase_out_next;
    result.busy  = scaled_next >= shs_pkg::DEG_STEP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled    <= '0;
      index     <= 3'd0;
      reverse   <= 1'b0;
      phase_out <= shs_pkg::COILS_OFF;
    end else if (fire) begin
      scaled    <= scaled_next;
      index     <= index_next;
      reverse   <= reverse_next;
      phase_out <= phase_out_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stepper_half_step_sequencer_unit.sv -----
// half-step sequencer for a four-phase stepper with active-low coil drive
// input stream: s_axis_tuser selects the item kind (0 tick, 1 start);
//   a start carries angle in degrees and direction, loading
//   angle * BEATS_PER_TURN / 360 beats (saturating at 131071)
// each tick with beats left drives the next half-step code, else 0xF
// output stream: one item per input item, phase nibble and busy flag
// path: an accepted item passes the input register, then the result
//   register; the beat state updates as an item moves on
// throughput: one item per cycle; the angle scaling multiply sits before
//   the input register, the beat countdown is a compare and subtract
// stall: a stalled output holds its item; the input register takes items
//   while it is empty or the result register is free or being drained
// reset: synchronous rst clears both valid flags, the beat count, the
//   phase index and direction, and turns all coils off (phase 0xF)
// BEATS_PER_TURN: 8 to 8192
`default_nettype none
module stepper_half_step_sequencer_unit #(
  parameter int BEATS_PER_TURN = 512
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // angle [15:0], direction [16], zero fill
  input  wire logic [shs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode [0]
  input  wire logic                               s_axis_tuser,
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // phase [3:0], busy_res [4], zero fill
  output      logic [shs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic                 advance;
  logic                 a_valid;
  shs_pkg::shs_item_t   a_item;
  shs_pkg::shs_result_t result;
  shs_pkg::shs_result_t res_reg;
  logic                 a_fire;

  assign advance = !m_axis_tvalid || m_axis_tready;
  assign a_fire  = a_valid && advance;

  shs_in_stage #(
    .BEATS_PER_TURN(BEATS_PER_TURN)
  ) u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mode      (s_axis_tuser),
    .angle     (s_axis_tdata[shs_pkg::ANGLE_W-1:0]),
    .direction (s_axis_tdata[shs_pkg::ANGLE_W]),
    .advance   (advance),
    .out_valid (a_valid),
    .out_item  (a_item)
  );

  shs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (a_fire),
    .item   (a_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      res_reg <= result;
    end
  end

  assign m_axis_tdata = {3'b000, res_reg.busy, res_reg.phase};

`include "stepper_half_step_sequencer_unit_assert.svh"

  `SHS_ASSERT_NOW(a_ready_when_out_free, !m_axis_tvalid, s_axis_tready,
    "input not ready while result register empty")

  `SHS_ASSERT_NEXT(a_start_busy,
    a_fire && a_item.start && (a_item.scaled >= shs_pkg::DEG_STEP),
    m_axis_tvalid && m_axis_tdata[4], "start with beats not reported busy")

  `SHS_ASSERT_NEXT(a_start_empty,
    a_fire && a_item.start && (a_item.scaled < shs_pkg::DEG_STEP),
    m_axis_tvalid && !m_axis_tdata[4] &&
      (m_axis_tdata[shs_pkg::PHASE_W-1:0] == shs_pkg::COILS_OFF),
    "empty start did not turn coils off")

endmodule
`default_nettype wire
